### hdl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the time-of-day text parser
// Parse phases, field widths, character codes and time scale constants.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int CHAR_W   = 8;
  localparam int FIELD_W  = 7;
  localparam int FRAC_W   = 20;
  localparam int PLACE_W  = 3;
  localparam int COUNT_W  = 2;
  localparam int DIGIT_W  = 4;
  localparam int SECS_W   = 17;
  localparam int MICROS_W = 37;

  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

  localparam logic [FIELD_W-1:0]  MAX_HOUR    = 7'd23;
  localparam logic [FIELD_W-1:0]  MAX_MIN_SEC = 7'd59;
  localparam logic [PLACE_W-1:0]  FRAC_DIGITS = 3'd6;
  localparam logic [COUNT_W-1:0]  MAX_DIGITS  = 2'd2;
  localparam logic [SECS_W-1:0]   SEC_PER_HOUR = 17'd3600;
  localparam logic [SECS_W-1:0]   SEC_PER_MIN  = 17'd60;
  localparam logic [MICROS_W-1:0] USEC_PER_SEC = 37'd1000000;
  localparam logic [MICROS_W-1:0] MICROS_LIMIT = 37'd86400000000;

  typedef enum logic [3:0] {
    PH_SKIP      = 4'd0,
    PH_HOUR      = 4'd1,
    PH_MIN_START = 4'd2,
    PH_MIN       = 4'd3,
    PH_SEC_START = 4'd4,
    PH_SEC       = 4'd5,
    PH_FRAC      = 4'd6,
    PH_DONE      = 4'd7,
    PH_FAIL      = 4'd8
  } parse_phase_t;

  // Fields of one finished string, handed from the scanner to the converter.
  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [FRAC_W-1:0]  fraction;
  } itp_fields_t;

  // Weight of a fraction digit at a given place (first place is 100000).
  function automatic logic [SECS_W-1:0] frac_weight(input logic [PLACE_W-1:0] place);
    logic [SECS_W-1:0] w;
    unique case (place)
      3'd0:    w = 17'd100000;
      3'd1:    w = 17'd10000;
      3'd2:    w = 17'd1000;
      3'd3:    w = 17'd100;
      3'd4:    w = 17'd10;
      3'd5:    w = 17'd1;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

### hdl/itp_in_if.sv
// ----------------------------------------------------------------------------
// itp_in_if: character channel of the time-of-day text parser
// Valid/ready channel carrying one text byte with presence and end marks.
// ----------------------------------------------------------------------------
interface itp_in_if;
  logic                        valid;
  logic                        ready;
  logic [itp_pkg::CHAR_W-1:0]  text_char;
  logic                        char_present;
  logic                        end_of_text;

  modport source (output valid, text_char, char_present, end_of_text, input ready);
  modport sink   (input valid, text_char, char_present, end_of_text, output ready);
endinterface

### hdl/itp_out_if.sv
// ----------------------------------------------------------------------------
// itp_out_if: result channel of the time-of-day text parser
// Valid/ready channel carrying the parse flag and microseconds since midnight.
// ----------------------------------------------------------------------------
interface itp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          parse_ok;
  logic [itp_pkg::MICROS_W-1:0]  time_micros;

  modport source (output valid, parse_ok, time_micros, input ready);
  modport sink   (input valid, parse_ok, time_micros, output ready);
endinterface

### hdl/iso_time_text_parser.sv
// ----------------------------------------------------------------------------
// iso_time_text_parser: streaming parser for a time of day hh:mm:ss[.ffffff]
// Takes one character per transaction and returns one result per string.
// ----------------------------------------------------------------------------
// Throughput: one character transaction per cycle in every phase, unless the
//   input stalls as below. The result of a string passes from the field
//   register to the seconds register and then to the output register.
// Each stage holds while the next is full and not draining; once all three
//   stages hold results and the receiver stalls, the character input stalls.
// Reset (rst, synchronous): parser returns to the leading-space phase with all
//   fields zero and every pipeline stage empty.
// ----------------------------------------------------------------------------
module iso_time_text_parser (
  input  logic       clk,
  input  logic       rst,
  itp_in_if.sink     text_in,
  itp_out_if.source  result_out
);

  // Fields of a finished string travel from the scanner to the converter.
  logic                  fields_valid;
  logic                  fields_ready;
  itp_pkg::itp_fields_t  fields;

  // Scanner: phase machine over the characters; one string at a time, the
  // finished fields are parked in a register so the next string can begin
  // immediately.
  itp_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .text_in      (text_in),
    .fields_valid (fields_valid),
    .fields_ready (fields_ready),
    .fields       (fields)
  );

  // Converter: hours, minutes, seconds to seconds of the day in one stage,
  // then one constant multiply by a million plus the fraction into the
  // output register.
  itp_convert u_convert (
    .clk          (clk),
    .rst          (rst),
    .fields_valid (fields_valid),
    .fields_ready (fields_ready),
    .fields       (fields),
    .result_out   (result_out)
  );

endmodule

### hdl/itp_scan.sv
// ----------------------------------------------------------------------------
// itp_scan: character scanner of the time-of-day text parser
// Phase machine over the text; registers the fields of each finished string.
// ----------------------------------------------------------------------------
module itp_scan (
  input  logic                 clk,
  input  logic                 rst,
  itp_in_if.sink               text_in,
  output logic                 fields_valid,
  input  logic                 fields_ready,
  output itp_pkg::itp_fields_t fields
);

  itp_pkg::parse_phase_t           phase, phase_next;
  logic [itp_pkg::COUNT_W-1:0]     digit_count, digit_count_next;
  logic [itp_pkg::FIELD_W-1:0]     hour_value, hour_value_next;
  logic [itp_pkg::FIELD_W-1:0]     minute_value, minute_value_next;
  logic [itp_pkg::FIELD_W-1:0]     second_value, second_value_next;
  logic [itp_pkg::FRAC_W-1:0]      fraction_value, fraction_value_next;
  logic [itp_pkg::PLACE_W-1:0]     fraction_place, fraction_place_next;

  logic                            accept;
  logic                            is_digit;
  logic                            is_blank;
  logic [itp_pkg::DIGIT_W-1:0]     digit;
  logic [itp_pkg::CHAR_W-1:0]      c;
  logic                            fields_ok;

  assign c        = text_in.text_char;
  assign is_digit = (c >= itp_pkg::CHAR_ZERO) && (c <= itp_pkg::CHAR_NINE);
  assign is_blank = (c == itp_pkg::CHAR_SPACE) ||
                    ((c >= itp_pkg::CHAR_TAB) && (c <= itp_pkg::CHAR_CR));
  assign digit    = is_digit ? itp_pkg::DIGIT_W'(c - itp_pkg::CHAR_ZERO) : '0;

  // Any item may enter while the field register is free or draining.
  assign text_in.ready = !fields_valid || fields_ready;
  assign accept        = text_in.valid && text_in.ready;

  // Append a digit to a one- or two-digit field.
  function automatic logic [itp_pkg::FIELD_W-1:0] shift_in(
    input logic [itp_pkg::FIELD_W-1:0] v,
    input logic [itp_pkg::DIGIT_W-1:0] d
  );
    logic [itp_pkg::FIELD_W+3:0] t;
    t = {4'd0, v} * 11'd10 + {7'd0, d};
    return t[itp_pkg::FIELD_W-1:0];
  endfunction

  always_comb begin
    phase_next          = phase;
    digit_count_next    = digit_count;
    hour_value_next     = hour_value;
    minute_value_next   = minute_value;
    second_value_next   = second_value;
    fraction_value_next = fraction_value;
    fraction_place_next = fraction_place;
    if (text_in.char_present) begin
      unique case (phase)
        itp_pkg::PH_SKIP: begin
          if (is_digit) begin
            hour_value_next  = itp_pkg::FIELD_W'(digit);
            digit_count_next = 2'd1;
            phase_next       = itp_pkg::PH_HOUR;
          end else if (!is_blank) begin
            phase_next = itp_pkg::PH_FAIL;
          end
        end
        itp_pkg::PH_HOUR: begin
          if (is_digit) begin
            if (digit_count >= itp_pkg::MAX_DIGITS) begin
              phase_next = itp_pkg::PH_FAIL;
            end else begin
              hour_value_next  = shift_in(hour_value, digit);
              digit_count_next = digit_count + 2'd1;
            end
          end else if (c == itp_pkg::CHAR_COLON) begin
            phase_next = itp_pkg::PH_MIN_START;
          end else begin
            phase_next = itp_pkg::PH_FAIL;
          end
        end
        itp_pkg::PH_MIN_START: begin
          if (is_digit) begin
            minute_value_next = itp_pkg::FIELD_W'(digit);
            digit_count_next  = 2'd1;
            phase_next        = itp_pkg::PH_MIN;
          end else begin
            phase_next = itp_pkg::PH_FAIL;
          end
        end
        itp_pkg::PH_MIN: begin
          if (is_digit) begin
            if (digit_count >= itp_pkg::MAX_DIGITS) begin
              phase_next = itp_pkg::PH_FAIL;
            end else begin
              minute_value_next = shift_in(minute_value, digit);
              digit_count_next  = digit_count + 2'd1;
            end
          end else if (c == itp_pkg::CHAR_COLON) begin
            phase_next = itp_pkg::PH_SEC_START;
          end else begin
            phase_next = itp_pkg::PH_FAIL;
          end
        end
        itp_pkg::PH_SEC_START: begin
          if (is_digit) begin
            second_value_next = itp_pkg::FIELD_W'(digit);
            digit_count_next  = 2'd1;
            phase_next        = itp_pkg::PH_SEC;
          end else begin
            phase_next = itp_pkg::PH_FAIL;
          end
        end
        itp_pkg::PH_SEC: begin
          if (is_digit) begin
            // A third seconds digit ends the parse but keeps the time.
            if (digit_count >= itp_pkg::MAX_DIGITS) begin
              phase_next = itp_pkg::PH_DONE;
            end else begin
              second_value_next = shift_in(second_value, digit);
              digit_count_next  = digit_count + 2'd1;
            end
          end else if (c == itp_pkg::CHAR_DOT) begin
            fraction_value_next = '0;
            fraction_place_next = '0;
            phase_next          = itp_pkg::PH_FRAC;
          end else begin
            phase_next = itp_pkg::PH_DONE;
          end
        end
        itp_pkg::PH_FRAC: begin
          if (is_digit) begin
            if (fraction_place < itp_pkg::FRAC_DIGITS) begin
              fraction_value_next = fraction_value + itp_pkg::FRAC_W'(
                {3'd0, itp_pkg::frac_weight(fraction_place)} * {16'd0, digit});
              fraction_place_next = fraction_place + 3'd1;
            end
          end else begin
            phase_next = itp_pkg::PH_DONE;
          end
        end
        itp_pkg::PH_DONE: begin
        end
        default: begin
          phase_next = itp_pkg::PH_FAIL;
        end
      endcase
    end
  end

  // Fraction never exceeds 999999, so only the phase and field ranges count.
  assign fields_ok = ((phase_next == itp_pkg::PH_SEC) || (phase_next == itp_pkg::PH_FRAC) ||
                      (phase_next == itp_pkg::PH_DONE)) &&
                     (hour_value_next <= itp_pkg::MAX_HOUR) &&
                     (minute_value_next <= itp_pkg::MAX_MIN_SEC) &&
                     (second_value_next <= itp_pkg::MAX_MIN_SEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      fields_valid   <= 1'b0;
      phase          <= itp_pkg::PH_SKIP;
      digit_count    <= '0;
      hour_value     <= '0;
      minute_value   <= '0;
      second_value   <= '0;
      fraction_value <= '0;
      fraction_place <= '0;
    end else begin
      if (accept && text_in.end_of_text) begin
        fields_valid <= 1'b1;
      end else if (fields_ready) begin
        fields_valid <= 1'b0;
      end
      if (accept) begin
        if (text_in.end_of_text) begin
          // Hand off the finished string and rearm for the next one.
          fields.ok       <= fields_ok;
          fields.hour     <= hour_value_next;
          fields.minute   <= minute_value_next;
          fields.second   <= second_value_next;
          fields.fraction <= fraction_value_next;
          phase          <= itp_pkg::PH_SKIP;
          digit_count    <= '0;
          hour_value     <= '0;
          minute_value   <= '0;
          second_value   <= '0;
          fraction_value <= '0;
          fraction_place <= '0;
        end else begin
          phase          <= phase_next;
          digit_count    <= digit_count_next;
          hour_value     <= hour_value_next;
          minute_value   <= minute_value_next;
          second_value   <= second_value_next;
          fraction_value <= fraction_value_next;
          fraction_place <= fraction_place_next;
        end
      end
    end
  end

endmodule

### hdl/itp_convert.sv
// ----------------------------------------------------------------------------
// itp_convert: time conversion of the time-of-day text parser
// Folds fields into seconds of the day, then scales to microseconds.
// ----------------------------------------------------------------------------
module itp_convert (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fields_valid,
  output logic                 fields_ready,
  input  itp_pkg::itp_fields_t fields,
  itp_out_if.source            result_out
);

  logic                          secs_valid;
  logic                          secs_ready;
  logic                          secs_ok;
  logic [itp_pkg::SECS_W-1:0]    day_secs;
  logic [itp_pkg::FRAC_W-1:0]    frac;
  logic [itp_pkg::SECS_W-1:0]    day_secs_next;
  logic [itp_pkg::MICROS_W-1:0]  micros_next;

  logic                          out_valid;
  logic                          out_ok;
  logic [itp_pkg::MICROS_W-1:0]  out_micros;

  assign secs_ready   = !out_valid || result_out.ready;
  assign fields_ready = !secs_valid || secs_ready;

  assign day_secs_next = itp_pkg::SECS_W'(fields.hour)   * itp_pkg::SEC_PER_HOUR +
                         itp_pkg::SECS_W'(fields.minute) * itp_pkg::SEC_PER_MIN +
                         itp_pkg::SECS_W'(fields.second);

  assign micros_next = itp_pkg::MICROS_W'(day_secs) * itp_pkg::USEC_PER_SEC +
                       itp_pkg::MICROS_W'(frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      secs_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fields_valid && fields_ready) begin
        secs_valid <= 1'b1;
        secs_ok    <= fields.ok;
        // Zero a failed parse here so the scaled result comes out as zero.
        day_secs   <= fields.ok ? day_secs_next : '0;
        frac       <= fields.ok ? fields.fraction : '0;
      end else if (secs_ready) begin
        secs_valid <= 1'b0;
      end
      if (secs_valid && secs_ready) begin
        out_valid  <= 1'b1;
        out_ok     <= secs_ok;
        out_micros <= micros_next;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.parse_ok    = out_ok;
  assign result_out.time_micros = out_micros;

endmodule

### hdl/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker: port-level checks of the time-of-day text parser
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module itp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          parse_ok,
  input logic [itp_pkg::MICROS_W-1:0]  time_micros
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(parse_ok) && $stable(time_micros))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !parse_ok |-> time_micros == '0)
    else $error("failed parse carries a nonzero time");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_ok |-> time_micros < itp_pkg::MICROS_LIMIT)
    else $error("time beyond one day");

endmodule

bind iso_time_text_parser itp_checker u_itp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .parse_ok    (result_out.parse_ok),
  .time_micros (result_out.time_micros)
);

### sim/iso_time_text_parser_tb.sv
// ----------------------------------------------------------------------------
// iso_time_text_parser_tb: self-checking bench for the time-of-day parser
// Streams character strings through the parser, predicts each result in a
// local scanner of its own, and compares every result transaction with the
// oldest pending prediction under random idling and back-pressure.
// ----------------------------------------------------------------------------
module iso_time_text_parser_tb;
  import itp_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 4;
  localparam int LONG_HOLD    = 250;   // receiver hold-off in the pressure test
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES = 20;    // idle wait once all results are checked
  localparam int RANDOM_ITEMS = 800;

  typedef struct {
    logic                ok;
    logic [MICROS_W-1:0] micros;
  } time_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  itp_in_if  text_if ();
  itp_out_if res_if ();

  iso_time_text_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_if),
    .result_out (res_if)
  );

  always #HALF_PERIOD clk = ~clk;

  // Predicted parser state, mirrors what the block holds between characters.
  parse_phase_t       scan_phase;
  logic [COUNT_W-1:0] scan_digits;
  logic [FIELD_W-1:0] scan_hour;
  logic [FIELD_W-1:0] scan_minute;
  logic [FIELD_W-1:0] scan_second;
  logic [FRAC_W-1:0]  scan_usec;
  logic [PLACE_W-1:0] scan_places;

  time_result_t time_expect_q[$];
  time_result_t head_time;
  logic [CHAR_W-1:0] text_buf[$];

  bit no_idle  = 1'b0;   // both sides run without gaps while set
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off

  int unsigned items_sent;
  int unsigned strings_sent;
  int unsigned results_seen;
  int unsigned valid_times;
  int unsigned long_holds;
  int unsigned drain_pauses;
  int unsigned error_count;
  int unsigned stall_cycles;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void clear_scan();
    scan_phase  = PH_SKIP;
    scan_digits = '0;
    scan_hour   = '0;
    scan_minute = '0;
    scan_second = '0;
    scan_usec   = '0;
    scan_places = '0;
  endfunction

  // Weight of a fraction digit: 100000 at the first place, down to 1.
  function automatic int unsigned place_weight(input logic [PLACE_W-1:0] place);
    int unsigned w;
    w = 100000;
    for (int i = 0; i < place; i++) w = w / 10;
    return w;
  endfunction

  function automatic logic [FIELD_W-1:0] append_digit(input logic [FIELD_W-1:0] f,
                                                       input logic [3:0] d);
    logic [FIELD_W-1:0] r;
    r = f * 7'd10 + {3'b000, d};
    return r;
  endfunction

  // Advance the scanner by one character.
  function automatic void scan_char(input logic [CHAR_W-1:0] c);
    logic       is_dig;
    logic       is_blank;
    logic [3:0] d;
    is_dig   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    d        = is_dig ? c[3:0] : 4'd0;
    case (scan_phase)
      PH_SKIP: begin
        if (!is_blank) begin
          if (is_dig) begin
            scan_hour   = {3'b000, d};
            scan_digits = 2'd1;
            scan_phase  = PH_HOUR;
          end else begin
            scan_phase = PH_FAIL;
          end
        end
      end
      PH_HOUR: begin
        if (is_dig) begin
          if (scan_digits >= MAX_DIGITS) begin
            scan_phase = PH_FAIL;
          end else begin
            scan_hour   = append_digit(scan_hour, d);
            scan_digits = scan_digits + 2'd1;
          end
        end else if (c == CHAR_COLON) begin
          scan_phase = PH_MIN_START;
        end else begin
          scan_phase = PH_FAIL;
        end
      end
      PH_MIN_START: begin
        if (is_dig) begin
          scan_minute = {3'b000, d};
          scan_digits = 2'd1;
          scan_phase  = PH_MIN;
        end else begin
          scan_phase = PH_FAIL;
        end
      end
      PH_MIN: begin
        if (is_dig) begin
          if (scan_digits >= MAX_DIGITS) begin
            scan_phase = PH_FAIL;
          end else begin
            scan_minute = append_digit(scan_minute, d);
            scan_digits = scan_digits + 2'd1;
          end
        end else if (c == CHAR_COLON) begin
          scan_phase = PH_SEC_START;
        end else begin
          scan_phase = PH_FAIL;
        end
      end
      PH_SEC_START: begin
        if (is_dig) begin
          scan_second = {3'b000, d};
          scan_digits = 2'd1;
          scan_phase  = PH_SEC;
        end else begin
          scan_phase = PH_FAIL;
        end
      end
      PH_SEC: begin
        // A third digit or any character other than a dot ends the parse and keeps the time.
        if (is_dig) begin
          if (scan_digits >= MAX_DIGITS) begin
            scan_phase = PH_DONE;
          end else begin
            scan_second = append_digit(scan_second, d);
            scan_digits = scan_digits + 2'd1;
          end
        end else if (c == CHAR_DOT) begin
          scan_usec   = '0;
          scan_places = '0;
          scan_phase  = PH_FRAC;
        end else begin
          scan_phase = PH_DONE;
        end
      end
      PH_FRAC: begin
        // Digits past the sixth are dropped without ending the fraction.
        if (is_dig) begin
          if (scan_places < FRAC_DIGITS) begin
            scan_usec   = FRAC_W'(scan_usec + d * place_weight(scan_places));
            scan_places = scan_places + 3'd1;
          end
        end else begin
          scan_phase = PH_DONE;
        end
      end
      PH_DONE: ;
      default: scan_phase = PH_FAIL;
    endcase
  endfunction

  // Close the current string: work out its result and start over.
  function automatic time_result_t close_string();
    time_result_t      r;
    logic [SECS_W-1:0] secs;
    r.ok = (scan_phase inside {PH_SEC, PH_FRAC, PH_DONE}) &&
           (scan_hour <= MAX_HOUR) && (scan_minute <= MAX_MIN_SEC) &&
           (scan_second <= MAX_MIN_SEC) && (scan_usec <= 20'd999999);
    r.micros = '0;
    if (r.ok) begin
      secs     = SECS_W'(scan_hour * 3600 + scan_minute * 60 + scan_second);
      r.micros = MICROS_W'(secs) * USEC_PER_SEC + MICROS_W'(scan_usec);
    end
    clear_scan();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Offer one character transaction and record it once accepted.
  task automatic send_item(input logic [CHAR_W-1:0] c, input logic present,
                           input logic last);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_if.valid        <= 1'b1;
    text_if.text_char    <= c;
    text_if.char_present <= present;
    text_if.end_of_text  <= last;
    do @(posedge clk); while (!text_if.ready);
    items_sent++;
    if (present) scan_char(c);
    if (last) begin
      time_expect_q.push_back(close_string());
      strings_sent++;
    end
  endtask

  // Send text_buf as one string; an empty buffer becomes the empty string.
  task automatic send_text(input bit split_end);
    int unsigned n;
    bit          end_alone;
    n         = text_buf.size();
    end_alone = split_end || (n == 0);
    for (int i = 0; i < n; i++) begin
      // Now and then slip in a transaction that carries nothing.
      if ($urandom_range(0, 19) == 0) send_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(text_buf[i], 1'b1, !end_alone && (i == n - 1));
    end
    if (end_alone) send_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Append one or two digits of v (values below ten may come zero-padded).
  function automatic void push_number(input int unsigned v);
    if (v >= 10 || $urandom_range(0, 1) == 1) text_buf.push_back(CHAR_ZERO + CHAR_W'(v / 10));
    text_buf.push_back(CHAR_ZERO + CHAR_W'(v % 10));
  endfunction

  function automatic int unsigned pick_field(input int unsigned top);
    if ($urandom_range(0, 9) == 0) return $urandom_range(top + 1, 99);
    return $urandom_range(0, top);
  endfunction

  // Build a mostly well-formed time string with random content and faults.
  function automatic void build_time_text();
    int unsigned pick;
    int unsigned pos;
    text_buf.delete();
    repeat ($urandom_range(0, 2)) begin
      pick = $urandom_range(0, 5);
      text_buf.push_back(pick == 5 ? CHAR_SPACE : CHAR_TAB + CHAR_W'(pick));
    end
    push_number(pick_field(23));
    text_buf.push_back(CHAR_COLON);
    push_number(pick_field(59));
    text_buf.push_back(CHAR_COLON);
    push_number(pick_field(59));
    if ($urandom_range(0, 2) != 0) begin
      text_buf.push_back(CHAR_DOT);
      repeat ($urandom_range(0, 8)) text_buf.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: text_buf[pos] = CHAR_W'($urandom_range(0, 255));
        1: while (text_buf.size() > pos) void'(text_buf.pop_back());
        default: text_buf.insert(pos, CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
      endcase
    end
  endfunction

  // Random bytes of any value, mostly rejected by the parser.
  function automatic void build_noise_text();
    text_buf.delete();
    repeat ($urandom_range(1, 5)) text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
  endfunction

  task automatic send_random_string();
    int unsigned kind;
    kind = $urandom_range(0, 15);
    if (kind == 0) text_buf.delete();
    else if (kind < 3) build_noise_text();
    else build_time_text();
    send_text($urandom_range(0, 7) == 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    // empty string, then lone bytes at both ends of the code range
    text_buf.delete();
    send_text(1'b1);
    text_buf.delete();
    text_buf.push_back(8'h00);
    send_text(1'b0);
    text_buf.delete();
    text_buf.push_back(8'hFF);
    send_text(1'b0);
    // string ends before the seconds digits
    load_text("1:2");
    send_text(1'b0);
    // third digit in the hour field
    load_text("123");
    send_text(1'b0);
    // leading blank, dot with no digits, an empty transaction, end on its own
    load_text("0:0:0.");
    text_buf.push_front(CHAR_CR);
    foreach (text_buf[i]) send_item(text_buf[i], 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    // latest valid time with a third seconds digit
    load_text("23:59:590");
    send_text(1'b0);
    // hour out of range, seconds followed by another character
    load_text("24:0:0x");
    send_text(1'b0);
  endtask

  // Hold the receiver off while the sender keeps streaming without gaps.
  task automatic test_receiver_hold();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (25) begin
      build_time_text();
      send_text(1'b0);
    end
    no_idle = 1'b0;
  endtask

  // Let every pending result come out before sending again.
  task automatic test_drain_pause();
    repeat (5) begin
      build_time_text();
      send_text(1'b0);
    end
    @(negedge clk);
    text_if.valid <= 1'b0;
    wait (time_expect_q.size() == 0);
    drain_pauses++;
    repeat (5) begin
      build_time_text();
      send_text(1'b0);
    end
  endtask

  task automatic test_no_idle_burst();
    no_idle = 1'b1;
    repeat (20) send_random_string();
    no_idle = 1'b0;
  endtask

  task automatic test_random_strings();
    int unsigned stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) send_random_string();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    text_if.valid        = 1'b0;
    text_if.text_char    = '0;
    text_if.char_present = 1'b0;
    text_if.end_of_text  = 1'b0;
    clear_scan();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_receiver_hold();
    test_drain_pause();
    test_no_idle_burst();
    test_random_strings();

    @(negedge clk);
    text_if.valid <= 1'b0;
    wait (time_expect_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d strings in %0d character transactions: %0d valid times, %0d rejected",
             strings_sent, items_sent, valid_times, results_seen - valid_times);
    $display("receiver long holds %0d, sender drain pauses %0d, mismatches %0d",
             long_holds, drain_pauses, error_count);
    if (error_count == 0) begin
      $display("iso_time_text_parser_tb: clean");
    end else begin
      $display("iso_time_text_parser_tb: errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off when asked
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned wait_n;
    res_if.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        wait_n   = LONG_HOLD;
        long_holds++;
      end else begin
        wait_n = draw_gap();
      end
      @(negedge clk);
      if (wait_n != 0) begin
        res_if.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (time_expect_q.size() == 0) begin
        $error("result with no pending string: parse_ok %0d time_micros %0d",
               res_if.parse_ok, res_if.time_micros);
        error_count++;
      end else begin
        head_time = time_expect_q.pop_front();
        results_seen++;
        if (head_time.ok) valid_times++;
        if (res_if.parse_ok !== head_time.ok) begin
          $error("parse_ok: expected %0d, actual %0d", head_time.ok, res_if.parse_ok);
          error_count++;
        end
        if (res_if.time_micros !== head_time.micros) begin
          $error("time_micros: expected %0d, actual %0d", head_time.micros, res_if.time_micros);
          error_count++;
        end
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (text_if.valid && text_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout with %0d results pending", time_expect_q.size());
        $display("iso_time_text_parser_tb: errors");
        $finish;
      end
    end
  end

endmodule
